### design/rdiv_pkg.sv
// Shared types and constants for the pipelined restoring integer divider.
// Used by every module in the design folder; depends on nothing else.
`timescale 1ns / 1ps

package rdiv_pkg;

  localparam int DATA_WIDTH = 32;

  typedef enum logic {
    OP_UNSIGNED = 1'b0,
    OP_SIGNED   = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
  } operands_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] quotient;
    logic                  divide_by_zero;
  } result_t;

  typedef struct packed {
    logic                  valid;
    logic                  negate;
    logic                  zero_divisor;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] dsr;
    logic [DATA_WIDTH-1:0] num;
  } step_t;

endpackage

### design/rdiv_step.sv
// One registered step of restoring division: one quotient bit per stage.
// Depends on rdiv_pkg for the step_t pipeline record.
`timescale 1ns / 1ps

module rdiv_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  rdiv_pkg::step_t prev,
  output rdiv_pkg::step_t step
);

  logic [rdiv_pkg::DATA_WIDTH:0]   shifted;
  logic [rdiv_pkg::DATA_WIDTH:0]   diff;
  logic                            fits;
  rdiv_pkg::step_t                 step_next;

  // The partial remainder stays below the divisor, so the shifted value
  // fits in one extra bit and the trial subtract decides the quotient bit.
  always_comb begin
    shifted   = {prev.rem, prev.num[rdiv_pkg::DATA_WIDTH-1]};
    diff      = shifted - {1'b0, prev.dsr};
    fits      = ~diff[rdiv_pkg::DATA_WIDTH];
    step_next = prev;
    step_next.rem = fits ? diff[rdiv_pkg::DATA_WIDTH-1:0]
                         : shifted[rdiv_pkg::DATA_WIDTH-1:0];
    step_next.num = {prev.num[rdiv_pkg::DATA_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step.valid <= 1'b0;
    end else if (en) begin
      step.valid <= step_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step.negate       <= step_next.negate;
      step.zero_divisor <= step_next.zero_divisor;
      step.rem          <= step_next.rem;
      step.dsr          <= step_next.dsr;
      step.num          <= step_next.num;
    end
  end

endmodule

### design/restoring_integer_divider.sv
// Top level of the pipelined radix-2 restoring integer divider.
// Depends on rdiv_pkg and instantiates one rdiv_step per quotient bit.
`timescale 1ns / 1ps

// The divider accepts one beat per cycle whenever operands_stall is low.
// The operand magnitudes are formed as the beat is accepted and registered,
// one pipeline stage per quotient bit runs the restoring subtract, and one
// register applies the sign and the zero divisor result. The whole pipeline
// holds while a finished result is stalled, so operands_stall follows
// result_stall when a result is waiting. Signed division truncates toward
// zero; a zero divisor returns all ones with divide_by_zero set.

module restoring_integer_divider (
  input  logic                clk,
  input  logic                rst,
  input  logic                operands_valid,
  output logic                operands_stall,
  input  rdiv_pkg::operands_t operands,
  output logic                result_valid,
  input  logic                result_stall,
  output rdiv_pkg::result_t   result
);

  localparam int W = rdiv_pkg::DATA_WIDTH;

  logic            advance;
  rdiv_pkg::step_t stage [W+1];
  rdiv_pkg::step_t front_next;
  logic            sign_a;
  logic            sign_b;
  logic            is_signed;
  logic [W-1:0]    quotient_next;

  assign advance        = ~(result_valid & result_stall);
  assign operands_stall = ~advance;

  always_comb begin
    is_signed = (operands.opcode == rdiv_pkg::OP_SIGNED);
    sign_a    = is_signed & operands.dividend[W-1];
    sign_b    = is_signed & operands.divisor[W-1];
    front_next.valid        = operands_valid;
    front_next.negate       = sign_a ^ sign_b;
    front_next.zero_divisor = (operands.divisor == '0);
    front_next.rem          = '0;
    front_next.dsr          = sign_b ? (~operands.divisor + 1'b1) : operands.divisor;
    front_next.num          = sign_a ? (~operands.dividend + 1'b1) : operands.dividend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage[0].valid <= 1'b0;
    end else if (advance) begin
      stage[0].valid <= front_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage[0].negate       <= front_next.negate;
      stage[0].zero_divisor <= front_next.zero_divisor;
      stage[0].rem          <= front_next.rem;
      stage[0].dsr          <= front_next.dsr;
      stage[0].num          <= front_next.num;
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_step
    rdiv_step u_step (
      .clk  (clk),
      .rst  (rst),
      .en   (advance),
      .prev (stage[i]),
      .step (stage[i+1])
    );
  end

  always_comb begin
    if (stage[W].zero_divisor) begin
      quotient_next = '1;
    end else if (stage[W].negate) begin
      quotient_next = ~stage[W].num + 1'b1;
    end else begin
      quotient_next = stage[W].num;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.quotient       <= quotient_next;
      result.divide_by_zero <= stage[W].zero_divisor;
    end
  end

endmodule
